/* rtl/glv_pkg.sv */
// shared types, constants and arithmetic helpers of the ice viscosity block
package glv_pkg;

    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned LOG_W     = 30;
    localparam int unsigned VAL_W     = 48;
    localparam int unsigned EXP_W     = 20;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned C_W       = 68;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FLUIDITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd2;

    localparam logic [VAL_W-1:0] OUT_MAX       = '1;
    localparam logic [VAL_W-1:0] VISC_FLOOR    = 48'd429497;
    localparam logic [EXP_W-1:0] EXP_MIN       = 20'd65536;
    localparam logic [EXP_W-1:0] EXP_MAX       = 20'd655360;
    localparam logic [VAL_W-1:0] RST_FLUIDITY  = 48'd322122547200;
    localparam logic [EXP_W-1:0] RST_EXPONENT  = 20'd196608;
    localparam logic [VAL_W-1:0] RST_FLOOR     = 48'd6575080;

    // derived prefactor terms handed from the config unit to the datapath
    typedef struct packed {
        logic             busy;
        logic [VAL_W-1:0] floor;
        logic [31:0]      e;
        logic [C_W-1:0]   c;
    } t_pref;

    // one log2 fraction step: square the Q1.31 mantissa, bit out on top
    function automatic logic [32:0] log_square(input logic [31:0] m);
        logic [63:0] sq;
        logic [32:0] m2;
        sq = 64'(m) * 64'(m);
        m2 = sq[63:31];
        return m2[32] ? {1'b1, m2[32:1]} : {1'b0, m2[31:0]};
    endfunction

    // leading one index and Q1.31 mantissa of a non-zero 48-bit value
    function automatic logic [37:0] log_norm(input logic [VAL_W-1:0] x);
        logic [5:0]       p;
        logic [VAL_W-1:0] sh;
        p = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (x[i]) p = 6'(i);
        end
        sh = x << (6'd47 - p);
        return {p, sh[47:16]};
    endfunction

    // integer square root, evaluated at elaboration for the exp2 table
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q1.31
    function automatic logic [31:0] exp_coef(input int idx);
        logic [63:0] c;
        c = isqrt64(64'd1 << 63);
        for (int j = 1; j < idx; j++) begin
            c = isqrt64(c << 31);
        end
        return c[31:0];
    endfunction

endpackage

/* rtl/glv_prefactor.sv */
// configuration registers and sequential derivation of the prefactor terms
module glv_prefactor
    import glv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data,
    output t_pref                o_pref
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_LOG   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;

    logic [VAL_W-1:0]     r_fluidity;
    logic [EXP_W-1:0]     r_exponent;
    logic [VAL_W-1:0]     r_floor;
    logic [2:0]           r_state;
    logic [5:0]           r_cnt;
    logic [EXP_W-1:0]     r_den;
    logic [EXP_W-1:0]     r_rem;
    logic [32:0]          r_q;
    logic [31:0]          r_m;
    logic [5:0]           r_p;
    logic [FRAC_BITS-1:0] r_f;
    logic [62:0]          r_prod;
    logic [31:0]          r_e;
    logic [C_W-1:0]       r_c;

    logic [EXP_W:0]   w_trial;
    logic [32:0]      w_sq;
    logic [37:0]      w_norm;
    logic [32:0]      w_e;
    logic [C_W-1:0]   w_pos;
    logic [EXP_W-1:0] w_nclamp;

    assign o_cfg_ready = 1'b1;

    // clamp the exponent to its legal range
    always_comb begin
        w_nclamp = r_exponent;
        if (r_exponent < EXP_MIN) w_nclamp = EXP_MIN;
        if (r_exponent > EXP_MAX) w_nclamp = EXP_MAX;
    end

    assign w_trial = {r_rem, (r_cnt == 6'd0)};
    assign w_sq    = log_square(r_m);
    assign w_norm  = log_norm((r_fluidity != '0) ? r_fluidity : VAL_W'(1));
    assign w_e     = 33'h1_0000_0000 - r_q;
    assign w_pos   = (C_W'(1) << 62) + (C_W'(r_q) << 30)
                   + (((C_W'(w_e) << 4) + (C_W'(w_e) << 2)) << 25);

    // register writes and sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fluidity <= RST_FLUIDITY;
            r_exponent <= RST_EXPONENT;
            r_floor    <= RST_FLOOR;
            r_state    <= ST_START;
            r_cnt      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLUIDITY: r_fluidity <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_W-1:0];
                CFG_FLOOR:    r_floor    <= i_cfg_data;
                default: ;
            endcase
            r_state <= ST_START;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_START: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd48) r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_cnt   <= '0;
                    r_state <= ST_LOG;
                end
                ST_LOG: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(FRAC_BITS - 1)) r_state <= ST_MUL;
                end
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath of the sequencer: restoring divide, log2, product and sum
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_START: begin
                r_den <= w_nclamp;
                r_rem <= '0;
                r_q   <= '0;
            end
            ST_DIV: begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= EXP_W'(w_trial - {1'b0, r_den});
                    r_q   <= {r_q[31:0], 1'b1};
                end else begin
                    r_rem <= w_trial[EXP_W-1:0];
                    r_q   <= {r_q[31:0], 1'b0};
                end
            end
            ST_NORM: begin
                r_p <= w_norm[37:32];
                r_m <= w_norm[31:0];
                r_f <= '0;
            end
            ST_LOG: begin
                r_m <= w_sq[31:0];
                r_f <= {r_f[FRAC_BITS-2:0], w_sq[32]};
            end
            ST_MUL: r_prod <= 63'(r_q) * 63'({r_p, r_f});
            ST_SUM: begin
                r_e <= w_e[31:0];
                r_c <= w_pos - (C_W'(1) << 57) - (C_W'(r_prod) << 1);
            end
            default: ;
        endcase
    end

    assign o_pref.busy  = (r_state != ST_IDLE);
    assign o_pref.floor = (r_floor != '0) ? r_floor : VAL_W'(1);
    assign o_pref.e     = r_e;
    assign o_pref.c     = r_c;

endmodule

/* rtl/glen_law_ice_viscosity_top.sv */
// Glen flow law effective viscosity, one point per word through a deep pipeline
// throughput: one word per cycle while the prefactor unit is not busy; the pipeline
//   advances as one whenever the output register is empty or being taken
// reset: synchronous, active low; clears all valid bits and restores the
//   default registers, then runs the prefactor derivation (also after every
//   configuration write), during which no input word is taken
module glen_law_ice_viscosity_top
    import glv_pkg::*;
#(
    parameter int GRAD_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [GRAD_WIDTH-1:0] i_du_dx,
    input  logic [GRAD_WIDTH-1:0] i_du_dy,
    input  logic [GRAD_WIDTH-1:0] i_du_dz,
    input  logic [GRAD_WIDTH-1:0] i_dv_dx,
    input  logic [GRAD_WIDTH-1:0] i_dv_dy,
    input  logic [GRAD_WIDTH-1:0] i_dv_dz,
    input  logic [GRAD_WIDTH-1:0] i_dw_dx,
    input  logic [GRAD_WIDTH-1:0] i_dw_dy,
    input  logic [GRAD_WIDTH-1:0] i_dw_dz,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VAL_W-1:0]      o_viscosity,
    output logic                  o_strain_clamped,
    output logic                  o_viscosity_limited,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VAL_W-1:0]      i_cfg_data
);

    localparam int LOG_N = FRAC_BITS;
    localparam logic [64:0] BIG_MAG = 65'd1 << 45;

    t_pref w_pref;
    logic  w_adv;

    glv_prefactor u_pref (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pref      (w_pref)
    );

    // whole pipeline moves when the output register can take a word
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv && !w_pref.busy;

    function automatic logic [64:0] mag_of(input logic [GRAD_WIDTH-1:0] raw);
        logic [GRAD_WIDTH-1:0] t;
        t = raw[GRAD_WIDTH-1] ? (~raw + 1'b1) : raw;
        return 65'(t);
    endfunction

    // returns {big, sum} of two signed magnitudes
    function automatic logic [65:0] pair_sum(input logic [64:0] a, input logic na,
                                             input logic [64:0] b, input logic nb);
        logic [64:0] s;
        logic        big;
        big = 1'b0;
        s   = '0;
        if (na == nb) begin
            if (a >= BIG_MAG || b >= BIG_MAG) big = 1'b1;
            else s = a + b;
        end else begin
            s = (a >= b) ? a - b : b - a;
        end
        if (s >= BIG_MAG) big = 1'b1;
        return {big, s};
    endfunction

    // stage 1: magnitudes, shear sums and overflow detection
    logic [GRAD_WIDTH-1:0] w_in [0:8];
    logic [64:0]           w_mag [0:8];
    logic                  w_sg [0:8];
    logic [65:0]           w_ps [0:2];
    logic                  w_big1;

    assign w_in[0] = i_du_dx;
    assign w_in[1] = i_du_dy;
    assign w_in[2] = i_du_dz;
    assign w_in[3] = i_dv_dx;
    assign w_in[4] = i_dv_dy;
    assign w_in[5] = i_dv_dz;
    assign w_in[6] = i_dw_dx;
    assign w_in[7] = i_dw_dy;
    assign w_in[8] = i_dw_dz;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_mag[i] = mag_of(w_in[i]);
            w_sg[i]  = w_in[i][GRAD_WIDTH-1];
        end
        w_ps[0] = pair_sum(w_mag[1], w_sg[1], w_mag[3], w_sg[3]);
        w_ps[1] = pair_sum(w_mag[2], w_sg[2], w_mag[6], w_sg[6]);
        w_ps[2] = pair_sum(w_mag[5], w_sg[5], w_mag[7], w_sg[7]);
        w_big1  = (w_mag[0] >= BIG_MAG) || (w_mag[4] >= BIG_MAG) || (w_mag[8] >= BIG_MAG)
                || w_ps[0][65] || w_ps[1][65] || w_ps[2][65];
    end

    logic        r1_v, r1_big;
    logic [44:0] r1_x [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_adv) r1_v <= i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_big  <= w_big1;
            r1_x[0] <= w_mag[0][44:0];
            r1_x[1] <= w_mag[4][44:0];
            r1_x[2] <= w_mag[8][44:0];
            r1_x[3] <= w_ps[0][44:0];
            r1_x[4] <= w_ps[1][44:0];
            r1_x[5] <= w_ps[2][44:0];
        end
    end

    // stage 2: partial products of the six squares
    logic        r2_v, r2_big;
    logic [43:0] r2_hh [0:5];
    logic [44:0] r2_hl [0:5];
    logic [45:0] r2_ll [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_adv) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_big <= r1_big;
            for (int i = 0; i < 6; i++) begin
                r2_hh[i] <= 44'(r1_x[i][44:23]) * 44'(r1_x[i][44:23]);
                r2_hl[i] <= 45'(r1_x[i][44:23]) * 45'(r1_x[i][22:0]);
                r2_ll[i] <= 46'(r1_x[i][22:0]) * 46'(r1_x[i][22:0]);
            end
        end
    end

    // stage 3: assemble the squares
    logic        r3_v, r3_big;
    logic [89:0] r3_sq [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_adv) r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_big <= r2_big;
            for (int i = 0; i < 6; i++) begin
                r3_sq[i] <= (90'(r2_hh[i]) << 46) + (90'(r2_hl[i]) << 24) + 90'(r2_ll[i]);
            end
        end
    end

    // stage 4: diagonal and shear partial sums
    logic        r4_v, r4_big;
    logic [91:0] r4_pa, r4_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_adv) r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_big <= r3_big;
            r4_pa  <= 92'(r3_sq[0]) + 92'(r3_sq[1]) + 92'(r3_sq[2]);
            r4_pb  <= 92'(r3_sq[3]) + 92'(r3_sq[4]) + 92'(r3_sq[5]);
        end
    end

    // stage 5: four times the invariant, scaled to Q8.40 with saturation
    logic [93:0]      w_tot;
    logic             r5_v;
    logic [VAL_W-1:0] r5_inv;

    assign w_tot = 94'({r4_pa, 1'b0}) + 94'(r4_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_adv) r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_inv <= (r4_big || (w_tot[93:90] != '0)) ? OUT_MAX : w_tot[89:42];
        end
    end

    // stage 6: raise the invariant to the floor
    logic             r6_v, r6_clamp;
    logic [VAL_W-1:0] r6_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_adv) r6_v <= r5_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_clamp <= (r5_inv < w_pref.floor);
            r6_inv   <= (r5_inv < w_pref.floor) ? w_pref.floor : r5_inv;
        end
    end

    // log2 of the invariant: normalise, then one squaring per stage
    logic                 r_lv [0:LOG_N];
    logic                 r_lc [0:LOG_N];
    logic [5:0]           r_lp [0:LOG_N];
    logic [31:0]          r_lm [0:LOG_N];
    logic [FRAC_BITS-1:0] r_lf [0:LOG_N];
    logic [37:0]          w_norm;

    assign w_norm = log_norm(r6_inv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lv[0] <= 1'b0;
        else if (w_adv) r_lv[0] <= r6_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lc[0] <= r6_clamp;
            r_lp[0] <= w_norm[37:32];
            r_lm[0] <= w_norm[31:0];
            r_lf[0] <= '0;
        end
    end

    for (genvar j = 0; j < LOG_N; j++) begin : g_log
        logic [32:0] w_sq;
        assign w_sq = log_square(r_lm[j]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_lv[j+1] <= 1'b0;
            else if (w_adv) r_lv[j+1] <= r_lv[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_lc[j+1] <= r_lc[j];
                r_lp[j+1] <= r_lp[j];
                r_lm[j+1] <= w_sq[31:0];
                r_lf[j+1] <= {r_lf[j][FRAC_BITS-2:0], w_sq[32]};
            end
        end
    end

    // exponent slope times log2 of the invariant
    logic        r_mv, r_mc;
    logic [61:0] r_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (w_adv) r_mv <= r_lv[LOG_N];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mc <= r_lc[LOG_N];
            r_mp <= 62'(w_pref.e) * 62'({r_lp[LOG_N], r_lf[LOG_N]});
        end
    end

    // log2 of the viscosity, split into integer part and fraction
    logic [C_W-1:0] w_d;
    logic           r_ev [0:LOG_N];
    logic           r_ec [0:LOG_N];
    logic           r_ez [0:LOG_N];
    logic           r_es [0:LOG_N];
    logic [5:0]     r_ek [0:LOG_N];
    logic [FRAC_BITS-1:0] r_ef [0:LOG_N];
    logic [31:0]    r_em [0:LOG_N];

    assign w_d = w_pref.c - C_W'(r_mp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev[0] <= 1'b0;
        else if (w_adv) r_ev[0] <= r_mv;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ec[0] <= r_mc;
            r_ez[0] <= w_d[C_W-1];
            r_es[0] <= (w_d[66:57] >= 10'd48);
            r_ek[0] <= w_d[62:57];
            r_ef[0] <= w_d[56:33];
            r_em[0] <= 32'h8000_0000;
        end
    end

    // exp2 of the fraction: one conditional constant multiply per stage
    for (genvar j = 0; j < LOG_N; j++) begin : g_exp
        localparam logic [31:0] COEF = exp_coef(j + 1);
        logic [63:0] w_prod;
        assign w_prod = 64'(r_em[j]) * 64'(COEF);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_ev[j+1] <= 1'b0;
            else if (w_adv) r_ev[j+1] <= r_ev[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ec[j+1] <= r_ec[j];
                r_ez[j+1] <= r_ez[j];
                r_es[j+1] <= r_es[j];
                r_ek[j+1] <= r_ek[j];
                r_ef[j+1] <= r_ef[j];
                r_em[j+1] <= r_ef[j][FRAC_BITS-1-j] ? w_prod[62:31] : r_em[j];
            end
        end
    end

    // final scaling, floor and saturation into the output register
    logic [VAL_W-1:0] w_shift;
    logic [VAL_W-1:0] w_visc;
    logic             w_lim;
    logic [5:0]       w_k;

    assign w_k = r_ek[LOG_N];

    always_comb begin
        if (w_k >= 6'd31) w_shift = VAL_W'(r_em[LOG_N]) << (w_k - 6'd31);
        else w_shift = VAL_W'(r_em[LOG_N] >> (6'd31 - w_k));
        priority if (r_ez[LOG_N]) begin
            w_visc = VISC_FLOOR;
            w_lim  = 1'b1;
        end else if (r_es[LOG_N]) begin
            w_visc = OUT_MAX;
            w_lim  = 1'b1;
        end else if (w_shift < VISC_FLOOR) begin
            w_visc = VISC_FLOOR;
            w_lim  = 1'b1;
        end else begin
            w_visc = w_shift;
            w_lim  = 1'b0;
        end
    end

    logic             r_out_v, r_out_c, r_out_l;
    logic [VAL_W-1:0] r_out_visc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (w_adv) r_out_v <= r_ev[LOG_N];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_visc <= w_visc;
            r_out_c    <= r_ec[LOG_N];
            r_out_l    <= w_lim;
        end
    end

    assign o_valid             = r_out_v;
    assign o_viscosity         = r_out_visc;
    assign o_strain_clamped    = r_out_c;
    assign o_viscosity_limited = r_out_l;

endmodule

/* rtl/glv_checker.sv */
// port-level checks of the viscosity block and their binding
module glv_checker
    import glv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [VAL_W-1:0] o_viscosity,
    input logic             o_viscosity_limited
);

    // a held word keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_viscosity))
        else $error("output word changed while stalled");

    // the viscosity never drops below its floor
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_viscosity >= VISC_FLOOR)
        else $error("viscosity below floor");

    // the limit flag only comes with a floored or saturated value
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_viscosity_limited |->
            (o_viscosity == VISC_FLOOR) || (o_viscosity == OUT_MAX))
        else $error("limit flag on an unlimited value");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

bind glen_law_ice_viscosity_top glv_checker u_glv_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_viscosity         (o_viscosity),
    .o_viscosity_limited (o_viscosity_limited)
);

/* dv/tb_glen_law_ice_viscosity_top.sv */
// testbench for the glen flow law ice viscosity block
`timescale 1ns / 1ps

module tb_glen_law_ice_viscosity_top;
    import glv_pkg::*;

    localparam int GW = 48;
    localparam logic [GW-1:0] GRAD_MAX = {1'b0, {(GW-1){1'b1}}};
    localparam logic [GW-1:0] GRAD_MIN = {1'b1, {(GW-1){1'b0}}};
    localparam logic [63:0] MAG_LIMIT = 64'd1 << 45;

    typedef logic [GW-1:0] t_grad_set [9];

    typedef struct {
        logic [VAL_W-1:0] viscosity;
        logic             clamped;
        logic             limited;
    } t_visc_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [GW-1:0]    grad_q [9];
    logic             o_valid;
    logic             i_ready;
    logic [VAL_W-1:0] o_viscosity;
    logic             o_strain_clamped;
    logic             o_viscosity_limited;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VAL_W-1:0] i_cfg_data;

    // predictor copy of the registers
    logic [VAL_W-1:0] fluidity_reg;
    logic [EXP_W-1:0] exponent_reg;
    logic [VAL_W-1:0] floor_reg;
    logic [63:0]      root_coef [1:24];

    t_visc_word pending_visc [$];
    int         fail_count;
    int         words_sent;
    int         words_checked;
    int         clamped_seen;
    int         limited_seen;
    bit         tx_idle_on;
    bit         rx_stall_on;
    int         stall_left;

    glen_law_ice_viscosity_top #(.GRAD_WIDTH(GW)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_du_dx            (grad_q[0]),
        .i_du_dy            (grad_q[1]),
        .i_du_dz            (grad_q[2]),
        .i_dv_dx            (grad_q[3]),
        .i_dv_dy            (grad_q[4]),
        .i_dv_dz            (grad_q[5]),
        .i_dw_dx            (grad_q[6]),
        .i_dw_dy            (grad_q[7]),
        .i_dw_dz            (grad_q[8]),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_viscosity        (o_viscosity),
        .o_strain_clamped   (o_strain_clamped),
        .o_viscosity_limited(o_viscosity_limited),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4ms;
        $display("[glen_law_ice_viscosity_top] ERROR");
        $finish;
    end

    // bitwise integer square root
    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > val) probe = probe >> 2;
        while (probe != 0) begin
            if (val >= root + probe) begin
                val  = val - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // log2 in q.24 of a non-zero value
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          lead;
        logic [63:0] mant;
        logic [63:0] frac;
        lead = 0;
        frac = '0;
        for (int i = 0; i < 64; i++) if (x[i]) lead = i;
        mant = (lead >= 31) ? (x >> (lead - 31)) : (x << (31 - lead));
        for (int i = 0; i < 24; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32)) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(lead) << 24) | frac;
    endfunction

    // 2^frac mantissa in q1.31
    function automatic logic [63:0] exp2_fixed(input logic [23:0] frac);
        logic [63:0] mant;
        mant = 64'd1 << 31;
        for (int i = 1; i <= 24; i++) begin
            if (frac[24-i]) mant = (mant * root_coef[i]) >> 31;
        end
        return mant;
    endfunction

    function automatic logic [48:0] shear_sum(input logic [63:0] a, input bit na,
                                              input logic [63:0] b, input bit nb,
                                              inout bit big);
        logic [63:0] s;
        if (na == nb) begin
            if (a >= MAG_LIMIT || b >= MAG_LIMIT) begin
                big = 1'b1;
                return '0;
            end
            s = a + b;
        end else begin
            s = (a >= b) ? a - b : b - a;
        end
        if (s >= MAG_LIMIT) big = 1'b1;
        return s[48:0];
    endfunction

    // expected viscosity word for one point
    function automatic t_visc_word predict_viscosity(input t_grad_set g);
        t_visc_word  res;
        logic [63:0] mag [9];
        bit          sgn [9];
        bit          big;
        logic [48:0] s1, s2, s3;
        logic [127:0] sum4;
        logic [63:0] inv, flr, fa, n, r, e, la, li, pos, neg, d, k, v, m;
        big = 1'b0;
        res.clamped = 1'b0;
        res.limited = 1'b0;
        for (int i = 0; i < 9; i++) begin
            sgn[i] = g[i][GW-1];
            mag[i] = 64'(sgn[i] ? GW'(-g[i]) : g[i]);
        end
        if (mag[0] >= MAG_LIMIT || mag[4] >= MAG_LIMIT || mag[8] >= MAG_LIMIT) big = 1'b1;
        s1 = shear_sum(mag[1], sgn[1], mag[3], sgn[3], big);
        s2 = shear_sum(mag[2], sgn[2], mag[6], sgn[6], big);
        s3 = shear_sum(mag[5], sgn[5], mag[7], sgn[7], big);
        sum4 = 2 * (128'(mag[0]) * mag[0] + 128'(mag[4]) * mag[4] + 128'(mag[8]) * mag[8])
             + 128'(s1) * s1 + 128'(s2) * s2 + 128'(s3) * s3;
        if (sum4 >= (128'd1 << 90)) big = 1'b1;
        inv = big ? 64'(OUT_MAX) : 64'(sum4 >> 42);
        flr = (floor_reg != 0) ? 64'(floor_reg) : 64'd1;
        if (inv < flr) begin
            inv = flr;
            res.clamped = 1'b1;
        end
        fa = (fluidity_reg != 0) ? 64'(fluidity_reg) : 64'd1;
        n = 64'(exponent_reg);
        if (n < 64'(EXP_MIN)) n = 64'(EXP_MIN);
        if (n > 64'(EXP_MAX)) n = 64'(EXP_MAX);
        r = (64'd1 << 48) / n;
        e = (64'd1 << 32) - r;
        la = log2_fixed(fa);
        li = log2_fixed(inv);
        pos = (64'd1 << 62) + (r << 30) + e * 20 * (64'd1 << 25);
        neg = (64'd1 << 57) + 2 * r * la + e * li;
        if (neg > pos) begin
            v = 0;
        end else begin
            d = pos - neg;
            k = d >> 57;
            if (k >= 48) begin
                v = 64'(OUT_MAX) + 1;
            end else begin
                m = exp2_fixed(d[56:33]);
                v = (k >= 31) ? (m << (k - 31)) : (m >> (31 - k));
            end
        end
        if (v < 64'(VISC_FLOOR)) begin
            v = 64'(VISC_FLOOR);
            res.limited = 1'b1;
        end else if (v > 64'(OUT_MAX)) begin
            v = 64'(OUT_MAX);
            res.limited = 1'b1;
        end
        res.viscosity = v[VAL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result check
    always @(posedge i_clk) begin
        t_visc_word want;
        if (i_rst_n && o_valid && i_ready) begin
            words_checked++;
            if (pending_visc.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_viscosity), 64'd0);
            end else begin
                want = pending_visc.pop_front();
                if (o_viscosity !== want.viscosity)
                    report_mismatch("viscosity", 64'(o_viscosity), 64'(want.viscosity));
                if (o_strain_clamped !== want.clamped)
                    report_mismatch("strain_clamped", 64'(o_strain_clamped), 64'(want.clamped));
                if (o_viscosity_limited !== want.limited)
                    report_mismatch("viscosity_limited", 64'(o_viscosity_limited),
                                    64'(want.limited));
                if (want.clamped) clamped_seen++;
                if (want.limited) limited_seen++;
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            stall_left = rx_stall_on ? $urandom_range(0, 7) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_ready <= (stall_left == 0);
    end

    // one point into the block
    task automatic send_point(input t_grad_set g);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) grad_q[i] <= g[i];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_visc.push_back(predict_viscosity(g));
        words_sent++;
    endtask

    // wait for the pipeline to empty
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_visc.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        drain();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FLUIDITY: fluidity_reg = data;
            CFG_EXPONENT: exponent_reg = data[EXP_W-1:0];
            CFG_FLOOR:    floor_reg    = data;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random point, field magnitudes mostly bounded by a per-point scale, some fields fully random
    function automatic t_grad_set rand_point();
        t_grad_set g;
        int        scale;
        logic [GW-1:0] val;
        scale = $urandom_range(0, GW - 1);
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                g[i] = GW'(rand64());
            end else begin
                val = GW'(rand64()) & ((GW'(1) << scale) - 1);
                g[i] = $urandom_range(0, 1) ? GW'(-val) : val;
            end
        end
        return g;
    endfunction

    function automatic logic [VAL_W-1:0] rand_scaled(input int lo_bits);
        int w;
        w = $urandom_range(lo_bits, VAL_W);
        return VAL_W'(rand64()) & ((VAL_W'(1) << w) - 1 | (w == VAL_W ? '1 : '0));
    endfunction

    task automatic test_directed_points;
        t_grad_set g;
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        // all zero: invariant raised to the floor
        foreach (g[i]) g[i] = '0;
        send_point(g);
        // extremes of every field
        foreach (g[i]) g[i] = GRAD_MAX;
        send_point(g);
        foreach (g[i]) g[i] = GRAD_MIN;
        send_point(g);
        foreach (g[i]) g[i] = (i % 2) ? GRAD_MAX : GRAD_MIN;
        send_point(g);
        foreach (g[i]) g[i] = {GW{1'b1}};
        send_point(g);
        // cancelling shear pairs of large magnitude
        foreach (g[i]) g[i] = '0;
        g[1] = GW'(1) << 46; g[3] = GW'(-(GW'(1) << 46));
        send_point(g);
        // diagonal at the saturation edge and just below
        foreach (g[i]) g[i] = '0;
        g[0] = GW'(1) << 45;
        send_point(g);
        g[0] = (GW'(1) << 45) - 1;
        send_point(g);
        // each field alone at unit strain
        for (int j = 0; j < 9; j++) begin
            foreach (g[i]) g[i] = '0;
            g[j] = GW'(1) << 40;
            send_point(g);
        end
        drain();
    endtask

    task automatic test_register_corners;
        t_grad_set g;
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        // exponent below and above range, high data bits ignored
        write_reg(CFG_EXPONENT, '0);
        for (int j = 0; j < 3; j++) send_point(rand_point());
        write_reg(CFG_EXPONENT, 48'hFFF_FFFF_FFFF);
        for (int j = 0; j < 3; j++) send_point(rand_point());
        write_reg(CFG_EXPONENT, 48'(EXP_MIN));
        // zero fluidity and zero floor with a zero point
        write_reg(CFG_FLUIDITY, '0);
        write_reg(CFG_FLOOR, '0);
        foreach (g[i]) g[i] = '0;
        send_point(g);
        for (int j = 0; j < 3; j++) send_point(rand_point());
        // highest fluidity, highest floor, widest exponent
        write_reg(CFG_FLUIDITY, OUT_MAX);
        write_reg(CFG_FLOOR, OUT_MAX);
        write_reg(CFG_EXPONENT, 48'(EXP_MAX));
        for (int j = 0; j < 3; j++) send_point(rand_point());
        write_reg(CFG_FLUIDITY, 48'd1);
        write_reg(CFG_FLOOR, 48'd1);
        for (int j = 0; j < 3; j++) send_point(rand_point());
        write_reg(CFG_FLUIDITY, RST_FLUIDITY);
        write_reg(CFG_EXPONENT, 48'(RST_EXPONENT));
        write_reg(CFG_FLOOR, RST_FLOOR);
        drain();
    endtask

    task automatic test_random_points;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                write_reg(CFG_FLUIDITY, rand_scaled(0));
                write_reg(CFG_EXPONENT, 48'($urandom_range(EXP_MIN - 4096, EXP_MAX + 4096)));
                write_reg(CFG_FLOOR, rand_scaled(0));
            end
            for (int j = 0; j < 100; j++) begin
                // input idling and output stalls come in offset stretches; at least one is always on
                tx_idle_on  = (j % 40) >= 15;
                rx_stall_on = ((j + 20) % 40) >= 15;
                send_point(rand_point());
            end
        end
        drain();
    endtask

    initial begin
        logic [63:0] c;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FLUIDITY;
        i_cfg_data  = '0;
        foreach (grad_q[i]) grad_q[i] = '0;
        stall_left    = 0;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        clamped_seen  = 0;
        limited_seen  = 0;
        tx_idle_on    = 1'b0;
        rx_stall_on   = 1'b0;
        fluidity_reg  = RST_FLUIDITY;
        exponent_reg  = RST_EXPONENT;
        floor_reg     = RST_FLOOR;
        // 2^(2^-i) table
        c = int_sqrt(64'd1 << 63);
        for (int i = 1; i <= 24; i++) begin
            root_coef[i] = c;
            c = int_sqrt(c << 31);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_points();
        test_register_corners();
        test_random_points();

        repeat (64) @(posedge i_clk);
        $display("points sent %0d, words checked %0d, floor raised %0d, limited %0d",
                 words_sent, words_checked, clamped_seen, limited_seen);
        if (fail_count == 0 && pending_visc.size() == 0) begin
            $display("[glen_law_ice_viscosity_top] OK");
        end else begin
            $display("[glen_law_ice_viscosity_top] ERROR");
        end
        $finish;
    end

endmodule
